// ===== rtl/ssrc_pkg.sv =====
package ssrc_pkg;

    localparam int ANGLE_W = 8;
    localparam int STEP_W  = 8;
    localparam int PULSE_W = 12;
    localparam int SETTLE_W = 6;
    localparam int WIDE_W  = 10;

    typedef enum logic {
        KIND_TICK = 1'b0,
        KIND_MOVE = 1'b1
    } t_kind;

    typedef enum logic {
        STATUS_OK   = 1'b0,
        STATUS_BUSY = 1'b1
    } t_status;

    typedef logic signed [ANGLE_W-1:0] t_angle;
    typedef logic        [STEP_W-1:0]  t_step;
    typedef logic        [PULSE_W-1:0] t_pulse;
    typedef logic        [SETTLE_W-1:0] t_settle;
    typedef logic signed [WIDE_W-1:0]  t_wide;

    localparam t_angle  ANGLE_MAX    = 8'sd90;
    localparam t_angle  ANGLE_MIN    = -8'sd90;
    localparam t_step   STEP_RESET   = 8'd1;
    localparam t_pulse  PULSE_SCALE  = 12'd11;
    localparam t_pulse  PULSE_BASE   = 12'd500;
    localparam t_pulse  PULSE_MAX    = 12'd2480;
    localparam t_settle SETTLE_TICKS = 6'd50;

endpackage

// ===== rtl/ssrc_if.sv =====
interface ssrc_in_if;
    logic                valid;
    logic                ready;
    ssrc_pkg::t_kind     kind;
    ssrc_pkg::t_step     step_size;
    ssrc_pkg::t_angle    goal_angle;

    modport source (output valid, kind, step_size, goal_angle, input ready);
    modport sink   (input valid, kind, step_size, goal_angle, output ready);
endinterface

interface ssrc_out_if;
    logic                valid;
    logic                ready;
    ssrc_pkg::t_status   cmd_status;
    logic                busy_res;
    logic                pulse_valid;
    ssrc_pkg::t_pulse    pulse_width_us;
    ssrc_pkg::t_angle    current_angle;

    modport source (output valid, cmd_status, busy_res, pulse_valid, pulse_width_us,
                    current_angle, input ready);
    modport sink   (input valid, cmd_status, busy_res, pulse_valid, pulse_width_us,
                    current_angle, output ready);
endinterface

// ===== rtl/servo_slew_ramp_controller.sv =====
// servo slew ramp controller
// i_cmd carries one request per handshake: a tick (kind 0) or a move
// command (kind 1) with step_size and goal_angle. o_res returns exactly one
// result per request, in order: command status, busy flag, pulse valid,
// pulse width in microseconds and the ramped angle after the request.
// a request is captured in an input register, evaluated against the ramp
// state in one pass of logic, and lands in a result register.
// one request per cycle is sustained while o_res.ready stays high; the input
// register and the ramp state update together, so each request sees the
// state left by the one before.
// when the receiver holds o_res.ready low the result register holds its
// value, the input register fills, and i_cmd.ready drops once both are full.
// synchronous active-low reset empties both registers and sets the ramp
// angle and goal to 0, the step to 1, the settle count to 0 and the block
// to idle.
module servo_slew_ramp_controller (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ssrc_in_if.sink       i_cmd,
    ssrc_out_if.source    o_res
);

    logic                r_in_valid;
    ssrc_pkg::t_kind     r_in_kind;
    ssrc_pkg::t_step     r_in_step;
    ssrc_pkg::t_angle    r_in_goal;

    ssrc_pkg::t_angle    r_ramp;
    ssrc_pkg::t_angle    r_goal;
    ssrc_pkg::t_step     r_step;
    logic                r_busy;
    ssrc_pkg::t_settle   r_settle;

    logic                r_out_valid;
    ssrc_pkg::t_status   r_out_status;
    logic                r_out_busy;
    logic                r_out_pvalid;
    ssrc_pkg::t_pulse    r_out_width;
    ssrc_pkg::t_angle    r_out_angle;

    ssrc_pkg::t_angle    n_ramp;
    ssrc_pkg::t_angle    n_goal;
    ssrc_pkg::t_step     n_step;
    logic                n_busy;
    ssrc_pkg::t_settle   n_settle;
    ssrc_pkg::t_status   n_status;
    logic                n_pvalid;
    ssrc_pkg::t_pulse    n_width;

    logic                w_advance;
    logic                w_in_take;
    ssrc_pkg::t_angle    w_clamped;
    ssrc_pkg::t_wide     w_ramp_x;
    ssrc_pkg::t_wide     w_goal_x;
    ssrc_pkg::t_wide     w_step_x;
    ssrc_pkg::t_wide     w_sum;
    ssrc_pkg::t_wide     w_diff;
    ssrc_pkg::t_settle   w_settle_inc;
    logic signed [8:0]   w_off9;
    ssrc_pkg::t_pulse    w_off;

    assign w_advance = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_cmd.ready = !r_in_valid || w_advance;
    assign w_in_take = i_cmd.valid && i_cmd.ready;

    // ramp arithmetic in a widened signed domain
    assign w_ramp_x = ssrc_pkg::t_wide'(r_ramp);
    assign w_goal_x = ssrc_pkg::t_wide'(r_goal);
    assign w_step_x = ssrc_pkg::t_wide'({2'b00, r_step});
    assign w_sum    = w_ramp_x + w_step_x;
    assign w_diff   = w_ramp_x - w_step_x;
    assign w_settle_inc = r_settle + 6'd1;

    always_comb begin
        if (r_in_goal > ssrc_pkg::ANGLE_MAX) begin
            w_clamped = ssrc_pkg::ANGLE_MAX;
        end else if (r_in_goal < ssrc_pkg::ANGLE_MIN) begin
            w_clamped = ssrc_pkg::ANGLE_MIN;
        end else begin
            w_clamped = r_in_goal;
        end
    end

    always_comb begin
        n_ramp   = r_ramp;
        n_goal   = r_goal;
        n_step   = r_step;
        n_busy   = r_busy;
        n_settle = r_settle;
        n_status = ssrc_pkg::STATUS_OK;
        n_pvalid = 1'b0;
        unique case (r_in_kind)
            ssrc_pkg::KIND_MOVE: begin
                if (r_busy) begin
                    n_status = ssrc_pkg::STATUS_BUSY;
                end else begin
                    n_goal = w_clamped;
                    n_step = r_in_step;
                    n_busy = 1'b1;
                end
            end
            ssrc_pkg::KIND_TICK: begin
                n_pvalid = 1'b1;
                if (r_ramp == r_goal) begin
                    if (!r_busy) begin
                        n_pvalid = 1'b0;
                    end else if (w_settle_inc == ssrc_pkg::SETTLE_TICKS) begin
                        n_settle = '0;
                        n_busy   = 1'b0;
                    end else begin
                        n_settle = w_settle_inc;
                    end
                end else if (r_ramp < r_goal) begin
                    n_ramp = (w_sum < w_goal_x) ? w_sum[7:0] : r_goal;
                end else begin
                    n_ramp = (w_diff > w_goal_x) ? w_diff[7:0] : r_goal;
                end
            end
            default: begin
                n_status = ssrc_pkg::STATUS_OK;
            end
        endcase
    end

    // pulse width from the updated angle
    assign w_off9 = 9'(n_ramp) + 9'sd90;
    assign w_off  = {4'b0000, w_off9[7:0]};
    always_comb begin
        if (n_pvalid) begin
            n_width = w_off * ssrc_pkg::PULSE_SCALE + ssrc_pkg::PULSE_BASE;
        end else begin
            n_width = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_kind <= i_cmd.kind;
            r_in_step <= i_cmd.step_size;
            r_in_goal <= i_cmd.goal_angle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp   <= '0;
            r_goal   <= '0;
            r_step   <= ssrc_pkg::STEP_RESET;
            r_busy   <= 1'b0;
            r_settle <= '0;
        end else if (w_advance) begin
            r_ramp   <= n_ramp;
            r_goal   <= n_goal;
            r_step   <= n_step;
            r_busy   <= n_busy;
            r_settle <= n_settle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_status <= n_status;
            r_out_busy   <= n_busy;
            r_out_pvalid <= n_pvalid;
            r_out_width  <= n_width;
            r_out_angle  <= n_ramp;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.cmd_status     = r_out_status;
    assign o_res.busy_res       = r_out_busy;
    assign o_res.pulse_valid    = r_out_pvalid;
    assign o_res.pulse_width_us = r_out_width;
    assign o_res.current_angle  = r_out_angle;

    a_idle_at_goal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_ramp == r_goal && r_settle == '0))
        else $error("idle while away from goal or settle count not clear");

    a_goal_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_goal <= ssrc_pkg::ANGLE_MAX && r_goal >= ssrc_pkg::ANGLE_MIN))
        else $error("stored goal outside angle limits");

    a_pulse_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_pvalid) |->
        (r_out_width >= ssrc_pkg::PULSE_BASE && r_out_width <= ssrc_pkg::PULSE_MAX
         && r_out_status == ssrc_pkg::STATUS_OK))
        else $error("pulse width out of range or pulse on rejected command");

    a_reject_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in_kind == ssrc_pkg::KIND_MOVE && r_busy) |=>
        ($stable(r_goal) && $stable(r_step) && r_busy))
        else $error("rejected command changed ramp state");

endmodule
